>>> hw/rtl/vwrt_pkg.sv
package vwrt_pkg;

	localparam int WAITER_DEPTH_DEF = 16;

	typedef enum logic [1:0] {
		FUNC_WAIT        = 2'd0,
		FUNC_WAIT_UNLESS = 2'd1,
		FUNC_ENTER       = 2'd2,
		FUNC_LEAVE       = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		KIND_QUEUED    = 3'd0,
		KIND_IMMEDIATE = 3'd1,
		KIND_INVALID   = 3'd2,
		KIND_FULL      = 3'd3,
		KIND_RELEASED  = 3'd4,
		KIND_DONE      = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_AGE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		func_t       func;
		logic [31:0] thread_id;
		logic [15:0] wait_count;
	} req_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] released_id;
		logic [31:0] frame_count;
		logic        in_vblank;
		logic        last;
	} rsp_t;

	// One table entry as held by a cell.
	typedef struct packed {
		logic [31:0] id;
		logic [15:0] count;
	} entry_t;

	// Per-cell control from the sequencer.
	typedef struct packed {
		logic shift;
		logic write;
	} cell_ctl_t;

endpackage

>>> hw/rtl/vblank_waiter_release_table.sv
// Channel | Direction | Handshake            | Beat payload
// req     | in        | req_valid, req_stall | vwrt_pkg::req_t (func, thread_id, wait_count)
// rsp     | out       | rsp_valid, rsp_stall | vwrt_pkg::rsp_t (kind, id, frame count, flag, last)
//
// A wait or leave request gives one beat from the output register.
// Enter vblank is accepted, then each occupied table entry passes through the head cell
// of the chain (a release beat when its count runs out), then the closing beat follows.
// The output register holds one beat; any stall there holds the aging walk in place.
// Reset clears the occupancy, the vblank flag and counter; the cell contents are left as
// they are, since no entry at or above the occupancy is ever read. No clearing pass runs.
module vblank_waiter_release_table #(
	parameter int WAITER_DEPTH = vwrt_pkg::WAITER_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  vwrt_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output vwrt_pkg::rsp_t rsp
);

	localparam int OCC_W = $clog2(WAITER_DEPTH + 1);

	// The table is a row of cells with cell 0 at the head. During aging, while the output
	// register can take a beat, the whole row shifts toward the head once per cycle, and
	// the head entry is either released or written back, decremented, at the slot where
	// it will sit when the walk ends: occupancy - 1 - released_so_far, in the shifted frame.

	vwrt_pkg::state_t  st_q, st_d;
	logic [OCC_W-1:0]  occ_q, occ_d;
	logic [OCC_W-1:0]  rd_q, rd_d;
	logic [OCC_W-1:0]  nrel_q, nrel_d;
	logic              flag_q, flag_d;
	logic [31:0]       cnt_q, cnt_d;
	logic              rsp_valid_q;
	vwrt_pkg::rsp_t    rsp_q, rsp_d;
	logic              rsp_ld;
	logic              out_free;

	logic              shift;
	logic              wr_en;
	logic [OCC_W-1:0]  wr_pos;
	vwrt_pkg::entry_t  wr_data;
	logic [15:0]       head_count_m1;

	vwrt_pkg::entry_t    cell_out [WAITER_DEPTH];
	vwrt_pkg::cell_ctl_t cell_ctl [WAITER_DEPTH];

	genvar gi;
	generate
		for (gi = 0; gi < WAITER_DEPTH; gi++) begin : g_cell
			vwrt_pkg::entry_t nbr;
			if (gi == WAITER_DEPTH - 1) begin : g_tail
				assign nbr = '0;
			end else begin : g_mid
				assign nbr = cell_out[gi+1];
			end
			assign cell_ctl[gi].shift = shift;
			assign cell_ctl[gi].write = wr_en && (wr_pos == OCC_W'(gi));
			vwrt_cell u_cell (
				.clk     (clk),
				.ctl     (cell_ctl[gi]),
				.nbr     (nbr),
				.wr_data (wr_data),
				.entry   (cell_out[gi])
			);
		end
	endgenerate

	// A new beat may enter the output register when it is empty or being drained.
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (st_q != vwrt_pkg::ST_IDLE) || !out_free;

	assign head_count_m1 = cell_out[0].count - 16'd1;

	always_comb begin
		st_d    = st_q;
		occ_d   = occ_q;
		rd_d    = rd_q;
		nrel_d  = nrel_q;
		flag_d  = flag_q;
		cnt_d   = cnt_q;
		shift   = 1'b0;
		wr_en   = 1'b0;
		wr_pos  = occ_q;
		wr_data = '0;
		rsp_ld  = 1'b0;
		rsp_d   = '0;
		rsp_d.frame_count = cnt_q;
		rsp_d.in_vblank   = flag_q;
		rsp_d.kind        = vwrt_pkg::KIND_DONE;
		unique case (st_q)
			vwrt_pkg::ST_IDLE: begin
				if (req_valid && !req_stall) begin
					rsp_ld     = 1'b1;
					rsp_d.last = 1'b1;
					unique case (req.func)
						vwrt_pkg::FUNC_WAIT: begin
							if (req.wait_count == 16'd0) begin
								rsp_d.kind = vwrt_pkg::KIND_INVALID;
							end else if (occ_q >= OCC_W'(WAITER_DEPTH)) begin
								rsp_d.kind = vwrt_pkg::KIND_FULL;
							end else begin
								rsp_d.kind    = vwrt_pkg::KIND_QUEUED;
								wr_en         = 1'b1;
								wr_data.id    = req.thread_id;
								wr_data.count = req.wait_count;
								occ_d         = occ_q + OCC_W'(1);
							end
						end
						vwrt_pkg::FUNC_WAIT_UNLESS: begin
							if (flag_q) begin
								rsp_d.kind = vwrt_pkg::KIND_IMMEDIATE;
							end else if (occ_q >= OCC_W'(WAITER_DEPTH)) begin
								rsp_d.kind = vwrt_pkg::KIND_FULL;
							end else begin
								rsp_d.kind    = vwrt_pkg::KIND_QUEUED;
								wr_en         = 1'b1;
								wr_data.id    = req.thread_id;
								wr_data.count = 16'd1;
								occ_d         = occ_q + OCC_W'(1);
							end
						end
						vwrt_pkg::FUNC_ENTER: begin
							// The release beats and the closing beat come later.
							rsp_ld = 1'b0;
							flag_d = 1'b1;
							cnt_d  = cnt_q + 32'd1;
							rd_d   = '0;
							nrel_d = '0;
							st_d   = (occ_q == '0) ? vwrt_pkg::ST_FINISH : vwrt_pkg::ST_AGE;
						end
						vwrt_pkg::FUNC_LEAVE: begin
							flag_d          = 1'b0;
							rsp_d.in_vblank = 1'b0;
							rsp_d.kind      = vwrt_pkg::KIND_DONE;
						end
						default: begin
							rsp_d.kind = vwrt_pkg::KIND_DONE;
						end
					endcase
				end
			end
			vwrt_pkg::ST_AGE: begin
				if (out_free) begin
					shift = 1'b1;
					rd_d  = rd_q + OCC_W'(1);
					if (head_count_m1 == 16'd0) begin
						rsp_ld            = 1'b1;
						rsp_d.kind        = vwrt_pkg::KIND_RELEASED;
						rsp_d.released_id = cell_out[0].id;
						rsp_d.last        = 1'b0;
						nrel_d            = nrel_q + OCC_W'(1);
					end else begin
						wr_en         = 1'b1;
						wr_pos        = occ_q - OCC_W'(1) - nrel_q;
						wr_data.id    = cell_out[0].id;
						wr_data.count = head_count_m1;
					end
					if (rd_q == occ_q - OCC_W'(1)) begin
						st_d  = vwrt_pkg::ST_FINISH;
						occ_d = occ_q - nrel_d;
					end
				end
			end
			vwrt_pkg::ST_FINISH: begin
				if (out_free) begin
					rsp_ld     = 1'b1;
					rsp_d.kind = vwrt_pkg::KIND_DONE;
					rsp_d.last = 1'b1;
					st_d       = vwrt_pkg::ST_IDLE;
				end
			end
			default: begin
				st_d = vwrt_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= vwrt_pkg::ST_IDLE;
			occ_q       <= '0;
			rd_q        <= '0;
			nrel_q      <= '0;
			flag_q      <= 1'b0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			occ_q  <= occ_d;
			rd_q   <= rd_d;
			nrel_q <= nrel_d;
			flag_q <= flag_d;
			cnt_q  <= cnt_d;
			if (rsp_ld) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_ld) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(WAITER_DEPTH))
		else $error("occupancy exceeds table depth");

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (wr_pos < OCC_W'(WAITER_DEPTH)))
		else $error("cell write outside the table");

	a_walk_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == vwrt_pkg::ST_AGE) |-> (rd_q < occ_q && nrel_q <= rd_q))
		else $error("aging walk ran past the occupied entries");

	a_release_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.kind == vwrt_pkg::KIND_RELEASED) |-> !rsp_q.last)
		else $error("release beat marked as last");

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != vwrt_pkg::ST_IDLE) |-> req_stall)
		else $error("request taken while the table walk is active");
`endif

endmodule

>>> hw/rtl/vwrt_cell.sv
module vwrt_cell (
	input  logic                clk,
	input  vwrt_pkg::cell_ctl_t ctl,
	input  vwrt_pkg::entry_t    nbr,
	input  vwrt_pkg::entry_t    wr_data,
	output vwrt_pkg::entry_t    entry
);

	vwrt_pkg::entry_t entry_q;

	// A direct write wins over the shift from the neighbor.
	always_ff @(posedge clk) begin
		if (ctl.write) begin
			entry_q <= wr_data;
		end else if (ctl.shift) begin
			entry_q <= nbr;
		end
	end

	assign entry = entry_q;

endmodule
